[rtl/prqs_pkg.sv]
// Shared types and constants for the priority ready queue scheduler.
package prqs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    typedef struct packed {
        logic        arrive;
        logic [15:0] job_id;
        logic [15:0] run_time;
        logic [7:0]  prio_level;
    } tick_t;

    typedef struct packed {
        logic        done_valid;
        logic [15:0] done_id;
        logic        start_valid;
        logic [15:0] start_id;
        logic        cpu_busy;
        logic [4:0]  queued;
        logic        dropped;
    } result_t;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] run;
        logic [7:0]  prio;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

[rtl/prqs_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
module prqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/priority_ready_queue_scheduler_core.sv]
// Sequence: an accepted tick steps the CPU, an arrival walks past queued entries of larger prio
// value (S_INS_RD, S_INS_CMP), a job may be dispatched (S_DISP, S_POP), then S_OUT strobes the result.
// One tick at a time; busy is high in every state but S_IDLE, through the result strobe cycle.
// Ready queue: circular sorted buffer in one RAM, insertion walks one entry per S_INS_RD/S_INS_CMP pair.
// Results are strobed for one cycle on result_valid; the receiver cannot stall.
// Reset (rst_n low, async) empties the queue and idles the CPU; RAM contents are not cleared.
module priority_ready_queue_scheduler_core
    import prqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  tick_t   tick,
    output logic    result_valid,
    output result_t result
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_DISP,
        S_POP,
        S_OUT
    } state_t;

    state_t        state_reg;
    logic [CW-1:0] count_reg;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] pos_reg;
    entry_t        new_reg;
    logic          busy_flag_reg;
    logic [15:0]   run_id_reg;
    logic [15:0]   rem_reg;
    logic          done_valid_reg;
    logic [15:0]   done_id_reg;
    logic          start_valid_reg;
    logic [15:0]   start_id_reg;
    logic          dropped_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t        rd_entry;

    logic          accept;
    logic          full;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] l);
        logic [AW:0] s;
        s = {1'b0, head} + (AW+1)'(l);
        if (s >= (AW+1)'(QUEUE_DEPTH))
        begin
            s = s - (AW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign accept   = start && (state_reg == S_IDLE);
    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign busy     = (state_reg != S_IDLE);
    assign rd_entry = entry_t'(ram_rdata);

    prqs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // RAM port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = phys(head_reg, pos_reg);
        ram_wdata = new_reg;
        ram_raddr = head_reg;
        unique case (state_reg)
            S_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_raddr = phys(head_reg, CW'(pos_reg - 1'b1));
                end
            end
            S_INS_CMP:
            begin
                ram_we = 1'b1;
                if (rd_entry.prio > new_reg.prio)
                begin
                    ram_wdata = rd_entry;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            head_reg        <= '0;
            pos_reg         <= '0;
            new_reg         <= '0;
            busy_flag_reg   <= 1'b0;
            run_id_reg      <= '0;
            rem_reg         <= '0;
            done_valid_reg  <= 1'b0;
            done_id_reg     <= '0;
            start_valid_reg <= 1'b0;
            start_id_reg    <= '0;
            dropped_reg     <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        new_reg.id      <= tick.job_id;
                        new_reg.run     <= (tick.run_time == '0) ? 16'd1 : tick.run_time;
                        new_reg.prio    <= tick.prio_level;
                        pos_reg         <= count_reg;
                        dropped_reg     <= tick.arrive && full;
                        start_valid_reg <= 1'b0;
                        start_id_reg    <= '0;
                        done_valid_reg  <= 1'b0;
                        done_id_reg     <= '0;
                        // CPU step does not depend on the insertion
                        if (busy_flag_reg)
                        begin
                            rem_reg <= rem_reg - 16'd1;
                            if (rem_reg == 16'd1)
                            begin
                                done_valid_reg <= 1'b1;
                                done_id_reg    <= run_id_reg;
                                busy_flag_reg  <= 1'b0;
                            end
                        end
                        state_reg <= (tick.arrive && !full) ? S_INS_RD : S_DISP;
                    end
                end
                S_INS_RD:
                begin
                    if (pos_reg == '0)
                    begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_DISP;
                    end
                    else
                    begin
                        state_reg <= S_INS_CMP;
                    end
                end
                S_INS_CMP:
                begin
                    if (rd_entry.prio > new_reg.prio)
                    begin
                        pos_reg   <= pos_reg - 1'b1;
                        state_reg <= S_INS_RD;
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    state_reg <= (!busy_flag_reg && count_reg != '0) ? S_POP : S_OUT;
                end
                S_POP:
                begin
                    run_id_reg      <= rd_entry.id;
                    rem_reg         <= rd_entry.run;
                    busy_flag_reg   <= 1'b1;
                    start_valid_reg <= 1'b1;
                    start_id_reg    <= rd_entry.id;
                    head_reg        <= phys(head_reg, CW'(1));
                    count_reg       <= count_reg - 1'b1;
                    state_reg       <= S_OUT;
                end
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid       = (state_reg == S_OUT);
    assign result.done_valid  = done_valid_reg;
    assign result.done_id     = done_id_reg;
    assign result.start_valid = start_valid_reg;
    assign result.start_id    = start_id_reg;
    assign result.cpu_busy    = busy_flag_reg;
    assign result.queued      = 5'(count_reg);
    assign result.dropped     = dropped_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.start_valid |-> result.cpu_busy)
        else $error("dispatch without busy CPU");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.done_valid && !result.start_valid |-> !result.cpu_busy)
        else $error("CPU busy after completion with no dispatch");

    a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid && !busy)
        else $error("result strobe longer than one cycle");

endmodule
